>>> hw/rtl/jhmi_pkg.sv
// ----------------------------------------------------------------------------
// jhmi_pkg
// Types, codes and constants shared by the joint histogram / mutual
// information unit and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package jhmi_pkg;

  localparam int DEF_MAX_BINS_X     = 64;
  localparam int DEF_MAX_BINS_Y     = 64;
  localparam int DEF_LOG_TABLE_BITS = 10;
  localparam int DEFAULT_BINS       = 64;
  localparam int CFG_IDX_W          = 3;

  localparam logic [31:0] LN2_Q24 = 32'd11629080;
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_X  = 3'd0,
    CFG_OFFSET_X = 3'd1,
    CFG_SCALE_Y  = 3'd2,
    CFG_OFFSET_Y = 3'd3,
    CFG_BINS_X   = 3'd4,
    CFG_BINS_Y   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_RANGE    = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_HXY_ZERO = 3'd3,
    STAT_SAT      = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_MAPX, ST_MAPY, ST_COL, ST_RD, ST_WR,
    ST_QLN, ST_QLN1, ST_QLN2, ST_ERD, ST_EDAT, ST_EL1, ST_EL2, ST_EACC,
    ST_DIV, ST_DIVW, ST_FIN, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_ROW, PH_COL, PH_BIN
  } phase_t;

  typedef enum logic [1:0] {
    DSEL_X, DSEL_Y, DSEL_XY, DSEL_NMI
  } dsel_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] sample_x;
    logic [15:0] sample_y;
    logic [7:0]  weight;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        entropy_x;
    logic [31:0]        entropy_y;
    logic [31:0]        joint_entropy;
    logic signed [31:0] mutual_info;
    logic [31:0]        normalized_mi;
    logic [31:0]        total_weight;
  } out_item_t;

  // floor(num / den) by shift and subtract; elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + k/2^bits) in Q.24 by the atanh series; evaluated at elaboration only
  function automatic logic [31:0] log_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] s2;
    logic [63:0] t;
    logic [63:0] n;
    logic [63:0] acc;
    d   = (64'd1 << (bits + 1)) + 64'(k);
    s   = udiv64((64'(k) << 30) + (d >> 1), d);
    s2  = (s * s) >> 30;
    t   = s;
    n   = 64'd1;
    acc = '0;
    for (int it = 0; it < 48; it++) begin
      if (t != 64'd0) begin
        acc = acc + udiv64(t, n);
        t   = (t * s2) >> 30;
        n   = n + 64'd2;
      end
    end
    return 32'((64'd2 * acc + 64'd32) >> 6);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/jhmi_ram.sv
// ----------------------------------------------------------------------------
// jhmi_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module jhmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/jhmi_log.sv
// ----------------------------------------------------------------------------
// jhmi_log
// Two-stage natural log in Q.24: leading-one search, then table plus e*ln2.
// ----------------------------------------------------------------------------
`default_nettype none

module jhmi_log #(
  parameter int LOG_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic [31:0] value,
  output logic [31:0] ln
);
  import jhmi_pkg::*;

  localparam int TAB_N = 1 << LOG_TABLE_BITS;
  localparam int NW    = 32 + LOG_TABLE_BITS;

  logic [31:0]               tab [TAB_N];
  logic [4:0]                top;
  logic [NW-1:0]             norm;
  logic [4:0]                e_r;
  logic [LOG_TABLE_BITS-1:0] k_r;
  logic                      nz_r;
  logic [31:0]               ln_r;

  for (genvar g = 0; g < TAB_N; g++) begin : g_tab
    localparam logic [31:0] ENTRY = log_entry(32'(g), 32'(LOG_TABLE_BITS));
    assign tab[g] = ENTRY;
  end

  always_comb begin
    top = '0;
    for (int b = 0; b < 32; b++) begin
      if (value[b]) begin
        top = 5'(b);
      end
    end
    norm = {value, {LOG_TABLE_BITS{1'b0}}} << (5'd31 - top);
  end

  always_ff @(posedge clk) begin
    e_r  <= top;
    k_r  <= norm[NW-2 -: LOG_TABLE_BITS];
    nz_r <= (value != 32'd0);
    ln_r <= nz_r ? 32'({27'd0, e_r} * LN2_Q24) + tab[k_r] : 32'd0;
  end

  assign ln = ln_r;

endmodule

`default_nettype wire

>>> hw/rtl/jhmi_div.sv
// ----------------------------------------------------------------------------
// jhmi_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jhmi_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  localparam int STEPS = 64;
  localparam int CNTW  = $clog2(STEPS);

  logic [63:0]     quo_r;
  logic [32:0]     rem_r;
  logic [31:0]     dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r;
  logic            done_r;
  logic [32:0]     rem_sh;
  logic [33:0]     diff;
  logic            ge;
  logic [32:0]     rem_nxt;

  always_comb begin
    rem_sh  = {rem_r[31:0], quo_r[63]};
    diff    = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge      = !diff[33];
    rem_nxt = ge ? diff[32:0] : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[62:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> hw/rtl/joint_histogram_mutual_info_unit.sv
// ----------------------------------------------------------------------------
// joint_histogram_mutual_info_unit
// Joint intensity histogram with entropy and mutual information readout.
// ----------------------------------------------------------------------------
// Sequencing: after reset the unit sweeps its stores with busy high. An add
// makes two passes through the shared multiplier, then a read and a write of
// the bin, row and column RAMs; the read and write are skipped when the bin is
// out of range. A clear does the same sweep, one RAM entry per cycle. A query
// with nothing stored skips the walk; otherwise each stored count goes through
// the log pipeline and the shared multiplier in turn, and the three entropies
// plus, unless the joint entropy is zero, the normalised MI each use the
// divider. Each item gives exactly one result on out_item, strobed by
// out_valid for one cycle; the receiver cannot stall it. start is taken only
// while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_histogram_mutual_info_unit #(
  parameter int MAX_BINS_X     = jhmi_pkg::DEF_MAX_BINS_X,
  parameter int MAX_BINS_Y     = jhmi_pkg::DEF_MAX_BINS_Y,
  parameter int LOG_TABLE_BITS = jhmi_pkg::DEF_LOG_TABLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  jhmi_pkg::in_item_t            in_item,
  output logic                          out_valid,
  output jhmi_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jhmi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import jhmi_pkg::*;

  localparam int RW        = $clog2(MAX_BINS_X);
  localparam int CW        = $clog2(MAX_BINS_Y);
  localparam int NXW       = $clog2(MAX_BINS_X + 1);
  localparam int NYW       = $clog2(MAX_BINS_Y + 1);
  localparam int BIN_DEPTH = MAX_BINS_X * MAX_BINS_Y;
  localparam int BAW       = $clog2(BIN_DEPTH);

  state_t   state_r, state_nxt;
  in_item_t item_r;
  phase_t   ph_r;
  dsel_t    dsel_r;
  status_t  status_r;

  logic [31:0] scale_x_r, offset_x_r, scale_y_r, offset_y_r;
  logic [6:0]  bins_x_r, bins_y_r;
  logic [31:0] total_r;
  logic signed [65:0] mul_r;
  logic [RW-1:0]  row_r;
  logic           row_ok_r;
  logic [CW-1:0]  col_r;
  logic [31:0] hx_r, hy_r, hxy_r, nmi_r, lnn_r, c_r;
  logic [63:0] acc_x_r, acc_y_r, acc_xy_r;
  logic        sat_r;
  logic [NXW-1:0] i_r;
  logic [NYW-1:0] j_r;
  logic [BAW-1:0] rowbase_r;
  logic [BAW-1:0] clr_cnt_r;
  logic           clr_reply_r;

  logic [NXW-1:0] nx;
  logic [NYW-1:0] ny;

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;

  // bin mapping
  logic [31:0]        map_off;
  logic signed [49:0] map_v, map_adj;
  logic [33:0]        map_q;
  logic [33:0]        map_lim;
  logic               map_ok;

  // RAM ports
  logic           bin_we, row_we, col_we;
  logic [BAW-1:0] bin_addr;
  logic [RW-1:0]  row_addr;
  logic [CW-1:0]  col_addr;
  logic [31:0]    bin_wd, row_wd, col_wd;
  logic [31:0]    bin_rd, row_rd, col_rd;
  logic [BAW-1:0] add_addr;

  // add update
  logic [32:0] bin_sum, row_sum, col_sum, tot_sum;
  logic        add_sat;

  // query walk
  logic [31:0] ph_data;
  logic [31:0] log_in, log_ln;
  logic [63:0] acc_sel;
  logic [64:0] acc_sum;
  logic        walk_end;

  // divider
  logic        div_start, div_done;
  logic [63:0] div_dividend, div_q;
  logic [31:0] div_divisor;
  logic [31:0] ent_val;

  // result
  logic [32:0]        hsum;
  logic signed [34:0] mi_diff;
  logic [31:0]        mi_sat;

  // --------------------------------------------------------------------------
  // Submodules
  // --------------------------------------------------------------------------
  jhmi_ram #(.WIDTH(32), .DEPTH(BIN_DEPTH)) u_bin_ram (
    .clk(clk), .we(bin_we), .addr(bin_addr), .wdata(bin_wd), .rdata(bin_rd)
  );

  jhmi_ram #(.WIDTH(32), .DEPTH(MAX_BINS_X)) u_row_ram (
    .clk(clk), .we(row_we), .addr(row_addr), .wdata(row_wd), .rdata(row_rd)
  );

  jhmi_ram #(.WIDTH(32), .DEPTH(MAX_BINS_Y)) u_col_ram (
    .clk(clk), .we(col_we), .addr(col_addr), .wdata(col_wd), .rdata(col_rd)
  );

  jhmi_log #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log (
    .clk(clk), .value(log_in), .ln(log_ln)
  );

  jhmi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_q)
  );

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  always_comb begin
    nx = ({25'd0, bins_x_r} > 32'(MAX_BINS_X)) ? NXW'(MAX_BINS_X) : NXW'(bins_x_r);
    ny = ({25'd0, bins_y_r} > 32'(MAX_BINS_Y)) ? NYW'(MAX_BINS_Y) : NYW'(bins_y_r);
  end

  // truncate toward zero: bias negative values before the shift
  always_comb begin
    map_off = (state_r == ST_MAPY) ? offset_x_r : offset_y_r;
    map_lim = (state_r == ST_MAPY) ? 34'(nx) : 34'(ny);
    map_v   = $signed(mul_r[49:0]) + $signed({{18{map_off[31]}}, map_off});
    map_adj = map_v[49] ? map_v + 50'sd65535 : map_v;
    map_q   = map_adj[49:16];
    map_ok  = !map_q[33] && (map_q < map_lim);
  end

  always_comb begin
    add_addr = BAW'(row_r) * BAW'(MAX_BINS_Y) + BAW'(col_r);
    bin_sum  = {1'b0, bin_rd} + 33'(item_r.weight);
    row_sum  = {1'b0, row_rd} + 33'(item_r.weight);
    col_sum  = {1'b0, col_rd} + 33'(item_r.weight);
    tot_sum  = {1'b0, total_r} + 33'(item_r.weight);
    add_sat  = bin_sum[32] | row_sum[32] | col_sum[32] | tot_sum[32];
  end

  always_comb begin
    unique case (ph_r)
      PH_ROW:  begin ph_data = row_rd; acc_sel = acc_x_r;  end
      PH_COL:  begin ph_data = col_rd; acc_sel = acc_y_r;  end
      default: begin ph_data = bin_rd; acc_sel = acc_xy_r; end
    endcase
    acc_sum  = {1'b0, acc_sel} + {1'b0, mul_r[63:0]};
    walk_end = (i_r >= nx) || (ny == '0);
  end

  always_comb begin
    ent_val = (div_q >= {32'd0, lnn_r}) ? 32'd0 : lnn_r - div_q[31:0];
    hsum    = {1'b0, hx_r} + {1'b0, hy_r};
    mi_diff = $signed({2'b00, hsum}) - $signed({3'b000, hxy_r});
    if (mi_diff > 35'sd2147483647) begin
      mi_sat = 32'h7FFF_FFFF;
    end else if (mi_diff < -35'sd2147483648) begin
      mi_sat = 32'h8000_0000;
    end else begin
      mi_sat = mi_diff[31:0];
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (clr_cnt_r == BAW'(BIN_DEPTH - 1)) begin
          state_nxt = clr_reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (mode_t'(in_item.mode))
            MODE_ADD:   state_nxt = ST_MAPX;
            MODE_CLEAR: state_nxt = ST_CLR;
            MODE_QUERY: state_nxt = (total_r == 32'd0) ? ST_DONE : ST_QLN;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MAPX: state_nxt = ST_MAPY;
      ST_MAPY: state_nxt = ST_COL;
      ST_COL:  state_nxt = (row_ok_r && map_ok) ? ST_RD : ST_DONE;
      ST_RD:   state_nxt = ST_WR;
      ST_WR:   state_nxt = ST_DONE;
      ST_QLN:  state_nxt = ST_QLN1;
      ST_QLN1: state_nxt = ST_QLN2;
      ST_QLN2: state_nxt = ST_ERD;
      ST_ERD: begin
        unique case (ph_r)
          PH_ROW:  state_nxt = (i_r >= nx) ? ST_ERD : ST_EDAT;
          PH_COL:  state_nxt = (j_r >= ny) ? ST_ERD : ST_EDAT;
          default: begin
            priority if (walk_end) state_nxt = ST_DIV;
            else if (j_r >= ny)    state_nxt = ST_ERD;
            else                   state_nxt = ST_EDAT;
          end
        endcase
      end
      ST_EDAT: state_nxt = ST_EL1;
      ST_EL1:  state_nxt = ST_EL2;
      ST_EL2:  state_nxt = ST_EACC;
      ST_EACC: state_nxt = ST_ERD;
      ST_DIV:  state_nxt = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          priority if (dsel_r == DSEL_NMI)                  state_nxt = ST_FIN;
          else if (dsel_r == DSEL_XY && ent_val == 32'd0)  state_nxt = ST_FIN;
          else                                              state_nxt = ST_DIV;
        end
      end
      ST_FIN:  state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control outputs
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    log_in    = '0;
    bin_we    = 1'b0;
    row_we    = 1'b0;
    col_we    = 1'b0;
    bin_addr  = '0;
    row_addr  = '0;
    col_addr  = '0;
    bin_wd    = '0;
    row_wd    = '0;
    col_wd    = '0;
    div_start = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        bin_we   = 1'b1;
        row_we   = (clr_cnt_r < BAW'(MAX_BINS_X));
        col_we   = (clr_cnt_r < BAW'(MAX_BINS_Y));
        bin_addr = clr_cnt_r;
        row_addr = clr_cnt_r[RW-1:0];
        col_addr = clr_cnt_r[CW-1:0];
      end
      ST_MAPX: begin
        mul_a = $signed({17'd0, item_r.sample_x});
        mul_b = $signed({scale_x_r[31], scale_x_r});
      end
      ST_MAPY: begin
        mul_a = $signed({17'd0, item_r.sample_y});
        mul_b = $signed({scale_y_r[31], scale_y_r});
      end
      ST_RD, ST_WR: begin
        bin_addr = add_addr;
        row_addr = row_r;
        col_addr = col_r;
        if (state_r == ST_WR) begin
          bin_we = 1'b1;
          row_we = 1'b1;
          col_we = 1'b1;
          bin_wd = bin_sum[32] ? U32_MAX : bin_sum[31:0];
          row_wd = row_sum[32] ? U32_MAX : row_sum[31:0];
          col_wd = col_sum[32] ? U32_MAX : col_sum[31:0];
        end
      end
      ST_QLN: log_in = total_r;
      ST_ERD: begin
        bin_addr = rowbase_r + BAW'(j_r);
        row_addr = i_r[RW-1:0];
        col_addr = j_r[CW-1:0];
      end
      ST_EDAT: log_in = ph_data;
      ST_EL2: begin
        mul_a = $signed({1'b0, c_r});
        mul_b = $signed({1'b0, log_ln});
      end
      ST_DIV: div_start = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    unique case (dsel_r)
      DSEL_X:  begin div_dividend = acc_x_r;  div_divisor = total_r; end
      DSEL_Y:  begin div_dividend = acc_y_r;  div_divisor = total_r; end
      DSEL_XY: begin div_dividend = acc_xy_r; div_divisor = total_r; end
      default: begin div_dividend = 64'(hsum) << 24; div_divisor = hxy_r; end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      total_r     <= '0;
      scale_x_r   <= 32'd64;
      offset_x_r  <= '0;
      scale_y_r   <= 32'd64;
      offset_y_r  <= '0;
      bins_x_r    <= 7'(DEFAULT_BINS);
      bins_y_r    <= 7'(DEFAULT_BINS);
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SCALE_X:  scale_x_r  <= cfg_data;
          CFG_OFFSET_X: offset_x_r <= cfg_data;
          CFG_SCALE_Y:  scale_y_r  <= cfg_data;
          CFG_OFFSET_Y: offset_y_r <= cfg_data;
          CFG_BINS_X:   bins_x_r   <= cfg_data[6:0];
          CFG_BINS_Y:   bins_y_r   <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (state_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == ST_IDLE && start && mode_t'(in_item.mode) == MODE_CLEAR) begin
        clr_cnt_r   <= '0;
        clr_reply_r <= 1'b1;
        total_r     <= '0;
      end
      if (state_r == ST_WR) begin
        total_r <= tot_sum[32] ? U32_MAX : tot_sum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_r    <= in_item;
          hx_r      <= '0;
          hy_r      <= '0;
          hxy_r     <= '0;
          nmi_r     <= '0;
          acc_x_r   <= '0;
          acc_y_r   <= '0;
          acc_xy_r  <= '0;
          sat_r     <= 1'b0;
          ph_r      <= PH_ROW;
          dsel_r    <= DSEL_X;
          i_r       <= '0;
          j_r       <= '0;
          rowbase_r <= '0;
          status_r  <= (mode_t'(in_item.mode) == MODE_QUERY && total_r == 32'd0)
                       ? STAT_EMPTY : STAT_OK;
        end
      end
      ST_MAPY: begin
        row_r    <= map_q[RW-1:0];
        row_ok_r <= map_ok;
      end
      ST_COL: begin
        col_r <= map_q[CW-1:0];
        if (!(row_ok_r && map_ok)) begin
          status_r <= STAT_RANGE;
        end
      end
      ST_WR: begin
        if (add_sat) begin
          status_r <= STAT_SAT;
        end
      end
      ST_QLN2: lnn_r <= log_ln;
      ST_ERD: begin
        unique case (ph_r)
          PH_ROW: begin
            if (i_r >= nx) begin
              ph_r <= PH_COL;
              j_r  <= '0;
            end
          end
          PH_COL: begin
            if (j_r >= ny) begin
              ph_r      <= PH_BIN;
              i_r       <= '0;
              j_r       <= '0;
              rowbase_r <= '0;
            end
          end
          default: begin
            // next row of the bin walk
            if (!walk_end && j_r >= ny) begin
              i_r       <= i_r + 1'b1;
              j_r       <= '0;
              rowbase_r <= rowbase_r + BAW'(MAX_BINS_Y);
            end
          end
        endcase
      end
      ST_EDAT: c_r <= ph_data;
      ST_EACC: begin
        if (c_r != 32'd0) begin
          unique case (ph_r)
            PH_ROW:  acc_x_r  <= acc_sum[64] ? '1 : acc_sum[63:0];
            PH_COL:  acc_y_r  <= acc_sum[64] ? '1 : acc_sum[63:0];
            default: acc_xy_r <= acc_sum[64] ? '1 : acc_sum[63:0];
          endcase
          if (acc_sum[64]) begin
            sat_r <= 1'b1;
          end
        end
        if (ph_r == PH_ROW) begin
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          unique case (dsel_r)
            DSEL_X:  begin hx_r  <= ent_val; dsel_r <= DSEL_Y;   end
            DSEL_Y:  begin hy_r  <= ent_val; dsel_r <= DSEL_XY;  end
            DSEL_XY: begin hxy_r <= ent_val; dsel_r <= DSEL_NMI; end
            default: nmi_r <= (div_q > 64'(U32_MAX)) ? U32_MAX : div_q[31:0];
          endcase
        end
      end
      ST_FIN: begin
        priority if (sat_r)        status_r <= STAT_SAT;
        else if (hxy_r == 32'd0)   status_r <= STAT_HXY_ZERO;
        else                       status_r <= STAT_OK;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == ST_DONE);

  always_comb begin
    out_item.status        = status_r;
    out_item.entropy_x     = hx_r;
    out_item.entropy_y     = hy_r;
    out_item.joint_entropy = hxy_r;
    out_item.mutual_info   = (hx_r == '0 && hy_r == '0 && hxy_r == '0) ? '0 : mi_sat;
    out_item.normalized_mi = nmi_r;
    out_item.total_weight  = total_r;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the unit busy");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIVW))
    else $error("divider finished outside its wait state");

endmodule

`default_nettype wire
